FILE: hdl/alb_pkg.sv
// shared types and constants for the antialiased line blender
// no dependencies
package alb_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_LINE  = 2'd2;

    localparam logic [1:0] REG_CANVAS_W = 2'd0;
    localparam logic [1:0] REG_CANVAS_H = 2'd1;
    localparam logic [1:0] REG_CLIP_W   = 2'd2;
    localparam logic [1:0] REG_CLIP_H   = 2'd3;

    localparam int RegW   = 7;

    typedef struct packed {
        logic        start;
        logic [15:0] num;
        logic [15:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quot;
        logic [15:0] rem;
    } div_rsp_t;

endpackage

FILE: hdl/antialiased_line_blender_top.sv
// antialiased line blender: canvas memory, line sequencer, blend unit
// depends on alb_pkg and alb_div
//
// Each beat is a pixel write, a pixel read or a line draw, and s_axis_tready is high
// only while idle with no read result waiting. A write passes through the setup and
// write states before the block is ready again. A read passes through setup, a memory
// read and an output state, then puts its result on m_axis and holds it until taken;
// the next beat can be taken the cycle after that. A line passes through setup and the
// clip check, then walks its steps through one shared 16-bit restoring divider and the
// single memory port (a read-modify-write blend): a vertical or horizontal step blends
// one pixel, a gentle step does one division and two blends, a steep step two divisions
// and two blends (the second blend is skipped when its weight is zero).
// The canvas needs no clearing after reset; reading a never-written pixel is
// undefined.
module antialiased_line_blender_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], start_x[7:2], start_y[13:8], end_x[19:14], end_y[25:20],
    // argb[57:26], zeros to 63
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_value[31:0]
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
    localparam int AddrW = $clog2(Depth);
    localparam int ProdW = 2 * alb_pkg::RegW;

    localparam logic [1:0] KIND_VERT   = 2'd0;
    localparam logic [1:0] KIND_HORIZ  = 2'd1;
    localparam logic [1:0] KIND_GENTLE = 2'd2;
    localparam logic [1:0] KIND_STEEP  = 2'd3;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_SETUP   = 14'b00000000000010,
        ST_PREP    = 14'b00000000000100,
        ST_DIV1    = 14'b00000000001000,
        ST_DIV1W   = 14'b00000000010000,
        ST_DIV2    = 14'b00000000100000,
        ST_DIV2W   = 14'b00000001000000,
        ST_P0      = 14'b00000010000000,
        ST_RD      = 14'b00000100000000,
        ST_RDW     = 14'b00001000000000,
        ST_WR      = 14'b00010000000000,
        ST_NEXT    = 14'b00100000000000,
        ST_RREAD   = 14'b01000000000000,
        ST_ROUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0] cw_reg, ch_reg, kw_reg, kh_reg;
    logic [31:0] mem [Depth];
    logic [31:0] rdata_reg;

    logic [1:0]  act;
    logic [5:0]  sx, sy, ex, ey;
    logic [31:0] argb_in;
    assign act = s_axis_tdata[1:0];
    assign sx = s_axis_tdata[7:2];
    assign sy = s_axis_tdata[13:8];
    assign ex = s_axis_tdata[19:14];
    assign ey = s_axis_tdata[25:20];
    assign argb_in = s_axis_tdata[57:26];

    // item registers
    logic [1:0]  act_reg;
    logic [5:0]  x1_reg, y1_reg, x2_reg, y2_reg;
    logic [31:0] col_reg;
    // line walk
    logic [1:0]  kind_reg;
    logic [6:0]  adx_reg, ady_reg;
    logic        neg_reg;
    logic [6:0]  i_reg, n_reg;
    logic [7:0]  e_reg;
    logic signed [8:0] row_reg;
    logic [7:0]  a_reg;
    logic signed [8:0] px_reg, py_reg;
    logic [7:0]  pa_reg;
    logic        second_reg, skip2_reg;
    logic [6:0]  q_reg;
    logic [31:0] dst_reg;
    logic        out_valid_reg;
    logic [31:0] out_reg;

    alb_pkg::div_req_t dreq;
    alb_pkg::div_rsp_t drsp;
    alb_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // pixel locate
    logic        in_cv;
    logic [ProdW:0] lin;
    logic [AddrW-1:0] addr;
    always_comb begin
        lin = {{(ProdW-6){1'b0}}, py_reg[6:0]} * {{(ProdW-6){1'b0}}, cw_reg}
            + {{(ProdW-6){1'b0}}, px_reg[6:0]};
        in_cv = !px_reg[8] && !py_reg[8] && ({1'b0, px_reg[7:0]} < {2'b0, cw_reg})
            && ({1'b0, py_reg[7:0]} < {2'b0, ch_reg}) && (32'(lin) < 32'(Depth));
        addr = AddrW'(lin);
    end

    // blend unit
    logic [31:0] blended;
    always_comb begin
        blended[31:24] = 8'hFF;
        for (int k = 0; k < 3; k++) begin
            blended[8*k +: 8] = 8'((({8'd0, col_reg[8*k +: 8]} * {8'd0, pa_reg})
                + ({8'd0, dst_reg[8*k +: 8]} * {8'd0, 8'hFF - pa_reg})) >> 8);
        end
    end

    logic [31:0] wdata;
    assign wdata = (act_reg == alb_pkg::ACT_WRITE) ? col_reg : blended;

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WR && in_cv) mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    always_comb begin
        dreq = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SETUP;
            ST_SETUP: begin
                if (act_reg == alb_pkg::ACT_WRITE) state_next = ST_WR;
                else if (act_reg == alb_pkg::ACT_READ) state_next = ST_RREAD;
                else if (act_reg == alb_pkg::ACT_LINE) state_next = ST_PREP;
                else state_next = ST_IDLE;
            end
            ST_PREP: begin
                if ({1'b0, x1_reg} >= kw_reg || {1'b0, x2_reg} >= kw_reg
                    || {1'b0, y1_reg} >= kh_reg || {1'b0, y2_reg} >= kh_reg
                    || (x1_reg == x2_reg && y1_reg == y2_reg))
                    state_next = ST_IDLE;
                else state_next = ST_DIV1;
            end
            ST_DIV1: begin
                dreq.start = kind_reg[1];
                if (kind_reg == KIND_GENTLE)
                    dreq.num = {e_reg, 8'd0};
                else
                    dreq.num = 16'(adx_reg * i_reg);
                dreq.den = (kind_reg == KIND_GENTLE) ? {8'd0, adx_reg, 1'b0}
                                                     : {9'd0, ady_reg};
                state_next = kind_reg[1] ? ST_DIV1W : ST_P0;
            end
            ST_DIV1W: if (drsp.done) state_next = (kind_reg == KIND_STEEP) ? ST_DIV2 : ST_P0;
            ST_DIV2: begin
                dreq.start = 1'b1;
                dreq.num = {drsp.rem[7:0], 8'd0};
                dreq.den = {9'd0, ady_reg};
                state_next = ST_DIV2W;
            end
            ST_DIV2W: if (drsp.done) state_next = ST_P0;
            ST_P0:   state_next = ST_RD;
            ST_RD:   state_next = ST_RDW;
            ST_RDW:  state_next = ST_WR;
            ST_WR: begin
                if (act_reg == alb_pkg::ACT_WRITE) state_next = ST_IDLE;
                else if (!second_reg && kind_reg[1] && !skip2_reg) state_next = ST_RD;
                else state_next = ST_NEXT;
            end
            ST_NEXT: state_next = (i_reg + 7'd1 >= n_reg) ? ST_IDLE : ST_DIV1;
            ST_RREAD: state_next = ST_ROUT;
            ST_ROUT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic [6:0] adx_c, ady_c;
    assign adx_c = (x2_reg > x1_reg) ? {1'b0, x2_reg - x1_reg} : {1'b0, x1_reg - x2_reg};
    assign ady_c = (y2_reg > y1_reg) ? {1'b0, y2_reg - y1_reg} : {1'b0, y1_reg - y2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cw_reg <= 7'd64; ch_reg <= 7'd64; kw_reg <= 7'd64; kh_reg <= 7'd64;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    alb_pkg::REG_CANVAS_W: cw_reg <= cfg_data;
                    alb_pkg::REG_CANVAS_H: ch_reg <= cfg_data;
                    alb_pkg::REG_CLIP_W:   kw_reg <= cfg_data;
                    alb_pkg::REG_CLIP_H:   kh_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_ROUT) out_valid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) out_valid_reg <= 1'b0;
        end
        case (state_reg)
            ST_IDLE: if (accept) begin
                act_reg <= act; x1_reg <= sx; y1_reg <= sy; x2_reg <= ex; y2_reg <= ey;
                col_reg <= argb_in;
            end
            ST_SETUP: begin
                px_reg <= {3'd0, x1_reg}; py_reg <= {3'd0, y1_reg};
                adx_reg <= adx_c; ady_reg <= ady_c;
                e_reg <= '0; i_reg <= '0;
                if (x1_reg == x2_reg) begin
                    kind_reg <= KIND_VERT; n_reg <= ady_c + 7'd1;
                    row_reg <= {3'd0, (y1_reg < y2_reg) ? y1_reg : y2_reg};
                end else if (y1_reg == y2_reg) begin
                    kind_reg <= KIND_HORIZ; n_reg <= adx_c + 7'd1;
                    row_reg <= {3'd0, (x1_reg < x2_reg) ? x1_reg : x2_reg};
                end else if (adx_c > ady_c) begin
                    kind_reg <= KIND_GENTLE; n_reg <= adx_c;
                    if (x2_reg < x1_reg) begin
                        x1_reg <= x2_reg; y1_reg <= y2_reg; x2_reg <= x1_reg; y2_reg <= y1_reg;
                        row_reg <= {3'd0, y2_reg};
                        neg_reg <= y1_reg < y2_reg;
                    end else begin
                        row_reg <= {3'd0, y1_reg};
                        neg_reg <= y2_reg < y1_reg;
                    end
                end else begin
                    kind_reg <= KIND_STEEP; n_reg <= ady_c;
                    if (y2_reg < y1_reg) begin
                        x1_reg <= x2_reg; y1_reg <= y2_reg; x2_reg <= x1_reg; y2_reg <= y1_reg;
                        neg_reg <= !(x1_reg > x2_reg);
                    end else neg_reg <= !(x2_reg > x1_reg);
                end
            end
            ST_DIV1W: if (drsp.done) begin
                q_reg <= drsp.quot[6:0];
                if (kind_reg == KIND_GENTLE) a_reg <= drsp.quot[7:0];
            end
            ST_DIV2W: if (drsp.done) a_reg <= drsp.quot[7:0];
            ST_P0: begin
                second_reg <= 1'b0;
                skip2_reg <= (kind_reg == KIND_STEEP) && (a_reg == 8'd0);
                unique case (kind_reg)
                    KIND_VERT: begin
                        px_reg <= {3'd0, x1_reg}; py_reg <= row_reg + 9'(i_reg);
                        pa_reg <= col_reg[31:24];
                    end
                    KIND_HORIZ: begin
                        px_reg <= row_reg + 9'(i_reg); py_reg <= {3'd0, y1_reg};
                        pa_reg <= col_reg[31:24];
                    end
                    KIND_GENTLE: begin
                        px_reg <= {3'd0, x1_reg} + 9'(i_reg); py_reg <= row_reg;
                        pa_reg <= 8'hFF - a_reg;
                    end
                    default: begin
                        px_reg <= neg_reg ? {3'd0, x1_reg} - 9'(q_reg)
                                          : {3'd0, x1_reg} + 9'(q_reg);
                        py_reg <= {3'd0, y1_reg} + 9'(i_reg);
                        pa_reg <= 8'hFF - a_reg;
                    end
                endcase
            end
            ST_RDW: dst_reg <= rdata_reg;
            ST_WR: begin
                if (act_reg != alb_pkg::ACT_WRITE) begin
                    second_reg <= 1'b1;
                    pa_reg <= a_reg;
                    if (kind_reg == KIND_GENTLE) py_reg <= neg_reg ? py_reg - 9'd1 : py_reg + 9'd1;
                    else px_reg <= neg_reg ? px_reg - 9'd1 : px_reg + 9'd1;
                end
            end
            ST_NEXT: begin
                i_reg <= i_reg + 7'd1;
                if (kind_reg == KIND_GENTLE) begin
                    if ({1'b0, e_reg} + {2'd0, ady_reg, 1'b0} >= {1'b0, adx_reg, 1'b0}) begin
                        e_reg <= 8'(e_reg + {ady_reg, 1'b0} - {adx_reg, 1'b0});
                        row_reg <= neg_reg ? row_reg - 9'd1 : row_reg + 9'd1;
                    end else e_reg <= 8'(e_reg + {ady_reg, 1'b0});
                end
            end
            ST_ROUT: out_reg <= in_cv ? rdata_reg : 32'd0;
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result lost");
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        dreq.start |-> !drsp.busy) else $error("divider restarted while busy");
`endif

endmodule

FILE: hdl/alb_div.sv
// restoring divider, one quotient bit per cycle
// depends on alb_pkg
module alb_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  alb_pkg::div_req_t req,
    output alb_pkg::div_rsp_t rsp
);

    logic [15:0] quot_reg, quot_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[15]} - {1'b0, den_reg};
        if (req.start) begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[16]) begin
                rem_next = trial[15:0];
                quot_next = {quot_reg[14:0], 1'b1};
            end else begin
                rem_next = {rem_reg[14:0], quot_reg[15]};
                quot_next = {quot_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule
